// ===== hdl/psfi_pkg.sv =====
// Package for the PNG stream frame indexer: item types, parse phases,
// signature and end-chunk constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psfi_pkg;

   localparam int POSITION_BITS_DEF = 32;
   localparam int QUEUE_DEPTH_DEF   = 2;

   localparam logic [7:0] SIG_BYTES [8] = '{
      8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
   };
   localparam logic [7:0] END_TYPE [4] = '{8'h49, 8'h45, 8'h4E, 8'h44};

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        frame_valid;
      logic [31:0] frame_offset;
      logic [31:0] frame_length;
      logic        buffer_done;
      logic [31:0] frame_total;
      logic        stopped_early;
   } rsp_type;

   // Byte plus its precomputed matches against the constant tables
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic [7:0] sig_match;
      logic [3:0] end_match;
   } class_item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [3:0] {
      PH_SIG  = 4'b0001,
      PH_HDR  = 4'b0010,
      PH_SKIP = 4'b0100,
      PH_HALT = 4'b1000
   } phase_type;

endpackage

`default_nettype wire

// ===== hdl/psfi_front.sv =====
// Front end: accepts input bytes and matches each against the signature and
// end-chunk tables before queueing. Depends on psfi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psfi_front
   import psfi_pkg::*;
(
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_data,
   input  wire queue_status_type q_status,
   output logic                  push,
   output class_item_type        push_item
);

   always_comb begin
      req_stall = q_status.full;
      push      = req_valid && !q_status.full;
      push_item.data_byte = req_data.data_byte;
      push_item.last_byte = req_data.last_byte;
      for (int i = 0; i < 8; i++) begin
         push_item.sig_match[i] = (req_data.data_byte == SIG_BYTES[i]);
      end
      for (int i = 0; i < 4; i++) begin
         push_item.end_match[i] = (req_data.data_byte == END_TYPE[i]);
      end
   end

endmodule

`default_nettype wire

// ===== hdl/psfi_queue.sv =====
// Short FIFO between the front end and the parser.
// Depends on psfi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psfi_queue
   import psfi_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire class_item_type push_item,
   input  wire logic           pop,
   output class_item_type      head_item,
   output queue_status_type    q_status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   class_item_type   slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item      = slot_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == CNT_FULL);

endmodule

`default_nettype wire

// ===== hdl/psfi_back.sv =====
// Parser: walks signature and chunks one byte per cycle unless stalled;
// reports frames, end-of-buffer summary via output reg. Depends on psfi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psfi_back
   import psfi_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire class_item_type   head_item,
   input  wire queue_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data
);

   localparam int P = POSITION_BITS;

   phase_type    phase_ff, phase_in;
   logic [P-1:0] pos_ff, pos_in;
   logic [P-1:0] start_ff, start_in;
   logic [2:0]   idx_ff, idx_in;
   logic [31:0]  clen_ff, clen_in;
   logic         is_end_ff, is_end_in;
   logic [32:0]  skip_ff, skip_in;
   logic [31:0]  found_ff, found_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   logic         take;
   logic         frame_end;
   logic         skip_done;
   logic [P-1:0] f_len;
   logic [63:0]  off_wide;
   logic [63:0]  len_wide;

   assign take = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign pop  = take;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      idx_in    = idx_ff;
      clen_in   = clen_ff;
      is_end_in = is_end_ff;
      skip_in   = skip_ff;
      found_in  = found_ff;
      frame_end = 1'b0;
      skip_done = (skip_ff <= 33'd1);
      f_len     = '0;

      if (take && phase_ff != PH_HALT) begin
         if (pos_ff == '1) begin
            // Position counter would wrap: stop parsing this buffer
            phase_in = PH_HALT;
         end else begin
            case (phase_ff)
               PH_SIG: begin
                  if (idx_ff == 3'd0) begin
                     start_in = pos_ff;
                  end
                  if (!head_item.sig_match[idx_ff]) begin
                     phase_in = PH_HALT;
                  end else if (idx_ff == 3'd7) begin
                     phase_in  = PH_HDR;
                     idx_in    = 3'd0;
                     is_end_in = 1'b1;
                  end else begin
                     idx_in = idx_ff + 3'd1;
                  end
               end
               PH_HDR: begin
                  if (!idx_ff[2]) begin
                     clen_in = (idx_ff == 3'd0) ? 32'(head_item.data_byte)
                                                : {clen_ff[23:0], head_item.data_byte};
                  end else if (!head_item.end_match[idx_ff[1:0]]) begin
                     is_end_in = 1'b0;
                  end
                  if (idx_ff == 3'd7) begin
                     // Chunk data plus the CRC
                     skip_in  = {1'b0, clen_ff} + 33'd4;
                     phase_in = PH_SKIP;
                     idx_in   = 3'd0;
                  end else begin
                     idx_in = idx_ff + 3'd1;
                  end
               end
               PH_SKIP: begin
                  skip_in = skip_done ? 33'd0 : skip_ff - 33'd1;
                  if (skip_done) begin
                     idx_in    = 3'd0;
                     is_end_in = 1'b1;
                     if (is_end_ff) begin
                        frame_end = 1'b1;
                        f_len     = pos_ff + 1'b1 - start_ff;
                        found_in  = (found_ff == 32'hFFFF_FFFF) ? found_ff
                                                                : found_ff + 32'd1;
                        phase_in  = PH_SIG;
                     end else begin
                        phase_in = PH_HDR;
                     end
                  end
               end
               default: begin
               end
            endcase
            pos_in = pos_ff + 1'b1;
         end
      end

      off_wide = 64'(start_ff);
      len_wide = 64'(f_len);

      rsp_data_in.frame_valid   = frame_end;
      rsp_data_in.frame_offset  = frame_end ? off_wide[31:0] : 32'd0;
      rsp_data_in.frame_length  = frame_end ? len_wide[31:0] : 32'd0;
      rsp_data_in.buffer_done   = head_item.last_byte;
      rsp_data_in.frame_total   = head_item.last_byte ? found_in : 32'd0;
      rsp_data_in.stopped_early = head_item.last_byte && (phase_in == PH_HALT);

      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = frame_end || head_item.last_byte;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Last byte closes the buffer: return to the reset state
      if (take && head_item.last_byte) begin
         phase_in  = PH_SIG;
         pos_in    = '0;
         start_in  = '0;
         idx_in    = 3'd0;
         clen_in   = 32'd0;
         is_end_in = 1'b1;
         skip_in   = 33'd0;
         found_in  = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SIG;
         pos_ff       <= '0;
         start_ff     <= '0;
         idx_ff       <= 3'd0;
         clen_ff      <= 32'd0;
         is_end_ff    <= 1'b1;
         skip_ff      <= 33'd0;
         found_ff     <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         start_ff     <= start_in;
         idx_ff       <= idx_in;
         clen_ff      <= clen_in;
         is_end_ff    <= is_end_in;
         skip_ff      <= skip_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hdl/png_stream_frame_indexer.sv =====
// PNG stream frame indexer: finds back-to-back PNG frames in a byte buffer.
// Top level; instantiates psfi_front, psfi_queue, psfi_back. Uses psfi_pkg.
//
// Usage:
//   req channel: one buffer byte per item (data_byte, last_byte marks the end
//   of the buffer). rsp channel: at most one item per byte, sent when a frame's
//   IEND CRC ends (frame_valid, frame_offset, frame_length) and/or on the last
//   byte (buffer_done, frame_total, stopped_early); both share one item when
//   they fall on the same byte.
//   Throughput is one byte per cycle while rsp is not stalled: the parser
//   handles one byte per clock, each step being a byte compare and a counter
//   update. A result passes through the queue and then the output register
//   before it is valid on rsp.
//   A two-entry queue sits between the front end and the parser; while rsp is
//   stalled the output register holds its item, the queue fills, and then
//   req_stall rises.
//   Reset empties the queue and output register and returns the parser to the
//   signature phase; the last byte of each buffer does the same to the parser.
`timescale 1ns / 1ps
`default_nettype none

module png_stream_frame_indexer
   import psfi_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   queue_status_type q_status;
   logic             push;
   logic             pop;
   class_item_type   push_item;
   class_item_type   head_item;

   psfi_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   psfi_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH_DEF)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   psfi_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_item (head_item),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.frame_valid || rsp_data.buffer_done))
      else $error("result carries neither a frame nor buffer end");

   a_summary_only_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.buffer_done) |->
         (rsp_data.frame_total == 32'd0 && !rsp_data.stopped_early))
      else $error("summary fields set without buffer_done");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("parser took an item from an empty queue");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
